### sv/fp_pkg.sv
// ----------------------------------------------------------------------------
// fp_pkg
// Shared types and constants of the frame parser: the frame phases, the
// status codes, and the structs passed between the top level and the
// frame walker.
// ----------------------------------------------------------------------------
package fp_pkg;

  localparam int ByteW = 8;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_SOURCE   = 3'd1,
    PH_DEST     = 3'd2,
    PH_TIME     = 3'd3,
    PH_TYPE     = 3'd4,
    PH_LENGTH   = 3'd5,
    PH_PAYLOAD  = 3'd6,
    PH_CHECKSUM = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_MORE  = 2'd0,
    ST_OK    = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  // Everything the parser keeps from one byte to the next.
  typedef struct packed {
    phase_t           phase;
    logic [ByteW-1:0] payload_count;
    logic [ByteW-1:0] src;
    logic [ByteW-1:0] dst;
    logic [ByteW-1:0] tstamp;
    logic [ByteW-1:0] mtype;
    logic [ByteW-1:0] length;
  } fp_state_t;

  // Per-byte report other than the stored header fields.
  typedef struct packed {
    status_t          status;
    logic             payload_valid;
    logic [ByteW-1:0] payload_index;
    logic [ByteW-1:0] payload_byte;
  } fp_report_t;

endpackage

### sv/fp_walker.sv
// ----------------------------------------------------------------------------
// fp_walker
// Combinational frame walker: one received byte against the current parser
// state gives the next state and the report for that byte.
// ----------------------------------------------------------------------------
module fp_walker (
  input  fp_pkg::fp_state_t           cur,
  input  logic [fp_pkg::ByteW-1:0]    rx_byte,
  input  logic [fp_pkg::ByteW-1:0]    header_byte,
  output fp_pkg::fp_state_t           nxt,
  output fp_pkg::fp_report_t          rpt
);

  logic [fp_pkg::ByteW-1:0] count_inc;
  logic [fp_pkg::ByteW-1:0] sum;

  assign count_inc = cur.payload_count + fp_pkg::ByteW'(1);
  assign sum       = cur.src + cur.dst + cur.tstamp + cur.length;

  always_comb begin
    nxt               = cur;
    rpt.status        = fp_pkg::ST_MORE;
    rpt.payload_valid = 1'b0;
    rpt.payload_index = '0;
    rpt.payload_byte  = '0;
    case (cur.phase)
      fp_pkg::PH_HEADER: begin
        // Bytes that do not match the header are dropped.
        if (rx_byte == header_byte) begin
          nxt.payload_count = '0;
          nxt.phase         = fp_pkg::PH_SOURCE;
        end
      end
      fp_pkg::PH_SOURCE: begin
        nxt.src   = rx_byte;
        nxt.phase = fp_pkg::PH_DEST;
      end
      fp_pkg::PH_DEST: begin
        nxt.dst   = rx_byte;
        nxt.phase = fp_pkg::PH_TIME;
      end
      fp_pkg::PH_TIME: begin
        nxt.tstamp = rx_byte;
        nxt.phase  = fp_pkg::PH_TYPE;
      end
      fp_pkg::PH_TYPE: begin
        nxt.mtype = rx_byte;
        nxt.phase = fp_pkg::PH_LENGTH;
      end
      fp_pkg::PH_LENGTH: begin
        nxt.length        = rx_byte;
        nxt.payload_count = '0;
        nxt.phase         = (rx_byte == '0) ? fp_pkg::PH_CHECKSUM : fp_pkg::PH_PAYLOAD;
      end
      fp_pkg::PH_PAYLOAD: begin
        rpt.payload_valid = 1'b1;
        rpt.payload_index = cur.payload_count;
        rpt.payload_byte  = rx_byte;
        nxt.payload_count = count_inc;
        if (count_inc == cur.length) begin
          nxt.phase = fp_pkg::PH_CHECKSUM;
        end
      end
      fp_pkg::PH_CHECKSUM: begin
        // Type and payload bytes are not covered by the checksum.
        rpt.status = (sum == rx_byte) ? fp_pkg::ST_OK : fp_pkg::ST_ERROR;
        nxt.phase  = fp_pkg::PH_HEADER;
      end
      default: begin
        nxt.phase = fp_pkg::PH_HEADER;
      end
    endcase
  end

endmodule

### sv/frame_parser.sv
// ----------------------------------------------------------------------------
// frame_parser
// Walks a byte stream frame by frame and reports payload bytes and the
// checksum verdict, one result transfer for every input transfer.
// ----------------------------------------------------------------------------
// A byte taken at the input passes the input register, then the result
// register. Throughput: one byte per cycle while out_stall is low; the input
// register and the result register together let a new byte in while a
// finished result waits to be taken.
// Reset (rst_n low, synchronous): both stages empty, parser in the header
// phase, all stored fields, the payload count and header_byte cleared.
// ----------------------------------------------------------------------------
module frame_parser (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       cfg_we,
  input  logic [7:0] cfg_header_byte,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic       out_payload_valid,
  output logic [7:0] out_payload_index,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_source_addr,
  output logic [7:0] out_dest_addr,
  output logic [7:0] out_time_stamp,
  output logic [7:0] out_msg_type,
  output logic [7:0] out_msg_length
);

  // Configuration: the byte value that opens a frame.
  logic [fp_pkg::ByteW-1:0] header_r;

  // Input register stage.
  logic                     s1_valid_r;
  logic [fp_pkg::ByteW-1:0] s1_byte_r;

  // Parser state, updated only when a byte moves into the result register.
  fp_pkg::fp_state_t        state_r;
  fp_pkg::fp_state_t        state_nxt;
  fp_pkg::fp_report_t       rpt;

  // Result register stage.
  logic                     out_valid_r;
  fp_pkg::fp_report_t       rpt_r;
  fp_pkg::fp_state_t        fields_r;

  logic                     out_free;
  logic                     s1_advance;
  logic                     in_take;

  // The result register can take a new entry when it is empty or is being
  // drained in this cycle; the input stage refills whenever it moves on.
  assign out_free   = !out_valid_r || !out_stall;
  assign s1_advance = s1_valid_r && out_free;
  assign in_stall   = s1_valid_r && !out_free;
  assign in_take    = in_valid && !in_stall;

  fp_walker u_walker (
    .cur         (state_r),
    .rx_byte     (s1_byte_r),
    .header_byte (header_r),
    .nxt         (state_nxt),
    .rpt         (rpt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= '0;
    end else if (cfg_we) begin
      header_r <= cfg_header_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Parser state commits only as the byte's result is captured, so the
  // stream is processed strictly in order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: fp_pkg::PH_HEADER, default: '0};
    end else if (s1_advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // The stored fields reported are those after this byte's update.
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      rpt_r    <= rpt;
      fields_r <= state_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = rpt_r.status;
  assign out_payload_valid = rpt_r.payload_valid;
  assign out_payload_index = rpt_r.payload_index;
  assign out_payload_byte  = rpt_r.payload_byte;
  assign out_source_addr   = fields_r.src;
  assign out_dest_addr     = fields_r.dst;
  assign out_time_stamp    = fields_r.tstamp;
  assign out_msg_type      = fields_r.mtype;
  assign out_msg_length    = fields_r.length;

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for frame_parser. The bench tracks the frame walk
// itself, byte by byte, builds the report it expects for every input
// transfer and compares each result transfer with it field by field.
// ----------------------------------------------------------------------------
module tb_top;

  // One expected result transfer, laid out as the result port.
  typedef struct packed {
    fp_pkg::status_t status;
    logic            payload_valid;
    logic [7:0]      payload_index;
    logic [7:0]      payload_byte;
    logic [7:0]      source_addr;
    logic [7:0]      dest_addr;
    logic [7:0]      time_stamp;
    logic [7:0]      msg_type;
    logic [7:0]      msg_length;
  } frame_report_t;

  // No transfer on either side for this many cycles means the block hung.
  // The longest legal quiet stretch is a sender gap plus a receiver stall
  // plus the time a byte spends in the block's registers.
  localparam int WatchdogLimit = 2000;
  // Settling time after the last result before a register write or the end.
  localparam int SettleCycles = 4;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_header_byte;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_status;
  logic       out_payload_valid;
  logic [7:0] out_payload_index;
  logic [7:0] out_payload_byte;
  logic [7:0] out_source_addr;
  logic [7:0] out_dest_addr;
  logic [7:0] out_time_stamp;
  logic [7:0] out_msg_type;
  logic [7:0] out_msg_length;

  frame_parser u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_header_byte   (cfg_header_byte),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_payload_valid (out_payload_valid),
    .out_payload_index (out_payload_index),
    .out_payload_byte  (out_payload_byte),
    .out_source_addr   (out_source_addr),
    .out_dest_addr     (out_dest_addr),
    .out_time_stamp    (out_time_stamp),
    .out_msg_type      (out_msg_type),
    .out_msg_length    (out_msg_length)
  );

  // Bench copy of the parser state and of the header register.
  fp_pkg::phase_t walk_phase;
  logic [7:0]     rx_count;
  logic [7:0]     frame_start;
  logic [7:0]     src_q;
  logic [7:0]     dst_q;
  logic [7:0]     ts_q;
  logic [7:0]     type_q;
  logic [7:0]     len_q;

  frame_report_t pending_reports[$];
  int            n_sent;
  int            n_errors;
  int            quiet_cycles;
  int            stall_left;
  bit            idle_on;

  always #10 clk = ~clk;

  // The frame checksum covers source, destination, time stamp and length.
  // The type byte and the payload are deliberately left out of it.
  function automatic logic [7:0] frame_sum(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c, input logic [7:0] d);
    return a + b + c + d;
  endfunction

  // Advances the bench copy of the frame walk by one received byte and
  // returns the report the block must produce for it. The stored fields
  // in the report are the ones after this byte's update.
  function automatic frame_report_t parse_byte(input logic [7:0] b);
    frame_report_t r;
    r = '0;
    case (walk_phase)
      fp_pkg::PH_HEADER: begin
        // Anything but the configured start byte is dropped silently.
        if (b == frame_start) begin
          rx_count   = '0;
          walk_phase = fp_pkg::PH_SOURCE;
        end
      end
      fp_pkg::PH_SOURCE: begin
        src_q      = b;
        walk_phase = fp_pkg::PH_DEST;
      end
      fp_pkg::PH_DEST: begin
        dst_q      = b;
        walk_phase = fp_pkg::PH_TIME;
      end
      fp_pkg::PH_TIME: begin
        ts_q       = b;
        walk_phase = fp_pkg::PH_TYPE;
      end
      fp_pkg::PH_TYPE: begin
        type_q     = b;
        walk_phase = fp_pkg::PH_LENGTH;
      end
      fp_pkg::PH_LENGTH: begin
        // An empty payload skips straight to the checksum byte.
        len_q      = b;
        rx_count   = '0;
        walk_phase = (b == 8'd0) ? fp_pkg::PH_CHECKSUM : fp_pkg::PH_PAYLOAD;
      end
      fp_pkg::PH_PAYLOAD: begin
        // Payload bytes always report "bytes remaining", even the last one.
        r.payload_valid = 1'b1;
        r.payload_index = rx_count;
        r.payload_byte  = b;
        rx_count        = rx_count + 8'd1;
        if (rx_count == len_q) walk_phase = fp_pkg::PH_CHECKSUM;
      end
      default: begin
        r.status   = (frame_sum(src_q, dst_q, ts_q, len_q) == b) ? fp_pkg::ST_OK
                                                                  : fp_pkg::ST_ERROR;
        walk_phase = fp_pkg::PH_HEADER;
      end
    endcase
    r.source_addr = src_q;
    r.dest_addr   = dst_q;
    r.time_stamp  = ts_q;
    r.msg_type    = type_q;
    r.msg_length  = len_q;
    return r;
  endfunction

  // Offers one byte, optionally after an idle burst, and waits for the
  // edge that takes it. The expected report is queued at that edge.
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_reports.push_back(parse_byte(b));
    n_sent++;
  endtask

  // Sends a whole frame from the header phase. With good cleared the
  // checksum byte is made wrong on purpose.
  task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
                            input logic [7:0] ts, input logic [7:0] mtype,
                            input logic [7:0] len, input bit good);
    logic [7:0] sum;
    sum = frame_sum(src, dst, ts, len);
    send_byte(frame_start);
    send_byte(src);
    send_byte(dst);
    send_byte(ts);
    send_byte(mtype);
    send_byte(len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom));
    send_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
  endtask

  // Random byte that will not open a frame.
  task automatic send_noise();
    logic [7:0] b;
    do b = 8'($urandom); while (b == frame_start);
    send_byte(b);
  endtask

  // Lets every outstanding result drain before the register is touched.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_header(input logic [7:0] value);
    drain();
    cfg_we          <= 1'b1;
    cfg_header_byte <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    frame_start  = value;
  endtask

  // Right after reset the start byte is zero: a stray byte is dropped and
  // an all-zero frame passes its checksum.
  task automatic test_reset_header();
    idle_on = 1'b1;
    send_byte(8'h3C);
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
  endtask

  // Field extremes, a dropped byte on each side of the range, a wrapping
  // checksum, a corrupted checksum, and a frame where only the type byte
  // would spoil the sum if it were counted.
  task automatic test_directed_frames();
    write_header(8'hA5);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h02, 1'b1);
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_frame(8'h12, 8'h34, 8'h56, 8'h9A, 8'h00, 1'b1);
  endtask

  // Phases of random traffic, each with its own start byte. Most of it is
  // well-formed frames with random content; the rest is line noise and
  // frames that are cut short and then run out with filler.
  task automatic test_random_traffic();
    int         seg_start;
    int         pick;
    logic [7:0] len;
    for (int seg = 0; seg < 5; seg++) begin
      case (seg)
        0: write_header(8'hFF);
        1: write_header(8'h00);
        default: write_header(8'($urandom));
      endcase
      // One phase runs with both sides at full speed.
      idle_on   = (seg != 2);
      seg_start = n_sent;
      // A maximum-length payload once, to reach the top payload index.
      if (seg == 0)
        send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'hFF, 1'b1);
      while (n_sent - seg_start < 40) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(7, 40))
                                            : 8'($urandom_range(0, 6));
          send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), len,
                     $urandom_range(0, 3) != 0);
        end else if (pick < 8) begin
          send_noise();
        end else begin
          // Truncated frame: a few small bytes after the start byte, then
          // filler until the walk is back in the header phase.
          send_byte(frame_start);
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 15)));
          while (walk_phase != fp_pkg::PH_HEADER) send_noise();
        end
      end
    end
  endtask

  // The closing stretch runs without any idling on either side.
  task automatic test_back_to_back();
    write_header(8'h5A);
    idle_on = 1'b0;
    for (int i = 0; i < 4; i++)
      send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom_range(0, 5)), i != 2);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Result side: every transfer is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    frame_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0h",
                 $time, out_status);
        n_errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", 8'(want.status), 8'(out_status));
        check_field("payload_valid", 8'(want.payload_valid), 8'(out_payload_valid));
        check_field("payload_index", want.payload_index, out_payload_index);
        check_field("payload_byte", want.payload_byte, out_payload_byte);
        check_field("source_addr", want.source_addr, out_source_addr);
        check_field("dest_addr", want.dest_addr, out_dest_addr);
        check_field("time_stamp", want.time_stamp, out_time_stamp);
        check_field("msg_type", want.msg_type, out_msg_type);
        check_field("msg_length", want.msg_length, out_msg_length);
      end
    end
  end

  // Receiver back-pressure in bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
    out_stall <= (stall_left > 0);
  end

  // Hang detection: counts cycles in which neither side moves a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WatchdogLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_header_byte = 8'h00;
    in_valid        = 1'b0;
    in_rx_byte      = 8'h00;
    out_stall       = 1'b0;
    idle_on         = 1'b0;
    stall_left      = 0;
    quiet_cycles    = 0;
    n_sent          = 0;
    n_errors        = 0;
    walk_phase      = fp_pkg::PH_HEADER;
    rx_count        = '0;
    frame_start     = '0;
    src_q           = '0;
    dst_q           = '0;
    ts_q            = '0;
    type_q          = '0;
    len_q           = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_header();
    test_directed_frames();
    test_random_traffic();
    test_back_to_back();

    drain();
    if (n_errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

### files.f
sv/fp_pkg.sv
sv/fp_walker.sv
sv/frame_parser.sv
test/tb_top.sv
